FILE: rtl/vwtc_pkg.sv
// shared constants and types for the voigt weighted tensor contraction
`default_nettype none

package vwtc_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int STORE_ROWS = 3;
	localparam int STORE_COLS = 6;
	localparam int TERMS_2D   = 3;
	localparam int ROW_W      = 2;
	localparam int VOIGT_W    = 3;
	localparam int DIMS_W     = 2;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_COLUMN = 1'b1;

	localparam logic [DIMS_W-1:0] DIMS_3D    = 2'd3;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

	// per-stage load enables shared by the lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} vwtc_adv_t;

endpackage

`default_nettype wire

FILE: rtl/vwtc_if.sv
// request, result and configuration channel interfaces
`default_nettype none

interface vwtc_in_if #(
	parameter int DW = vwtc_pkg::DATA_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic [vwtc_pkg::ROW_W-1:0]        a_row;
	logic [vwtc_pkg::VOIGT_W-1:0]      a_voigt;
	logic signed [DW-1:0]              a_value;
	logic signed [DW-1:0]              b_0;
	logic signed [DW-1:0]              b_1;
	logic signed [DW-1:0]              b_2;
	logic signed [DW-1:0]              b_3;
	logic signed [DW-1:0]              b_4;
	logic signed [DW-1:0]              b_5;

	modport source (output valid, func, a_row, a_voigt, a_value, b_0, b_1, b_2, b_3, b_4, b_5,
		input ready);
	modport sink (input valid, func, a_row, a_voigt, a_value, b_0, b_1, b_2, b_3, b_4, b_5,
		output ready);
endinterface

interface vwtc_out_if #(
	parameter int DW = vwtc_pkg::DATA_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] c_0;
	logic signed [DW-1:0] c_1;
	logic signed [DW-1:0] c_2;
	logic                 saturated;

	modport source (output valid, c_0, c_1, c_2, saturated, input ready);
	modport sink (input valid, c_0, c_1, c_2, saturated, output ready);
endinterface

interface vwtc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [vwtc_pkg::DIMS_W-1:0]   space_dims;

	modport source (output valid, space_dims, input ready);
	modport sink (input valid, space_dims, output ready);
endinterface

`default_nettype wire

FILE: rtl/vwtc_lane.sv
// one row lane: six multipliers, weighted adder tree, rounding and saturation
`default_nettype none

module vwtc_lane #(
	parameter int DW = vwtc_pkg::DATA_WIDTH_DEF,
	parameter int FB = vwtc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire vwtc_pkg::vwtc_adv_t                      adv,
	input  wire logic                                     three_d,
	input  wire logic [vwtc_pkg::STORE_COLS-1:0][DW-1:0]  a_row,
	input  wire logic [vwtc_pkg::STORE_COLS-1:0][DW-1:0]  b_col,
	output logic signed [DW-1:0]                          c,
	output logic                                          sat
);
	import vwtc_pkg::*;

	localparam int PW    = 2 * DW;
	localparam int SW    = PW + 4;
	localparam int RW    = SW - FB;
	localparam int NPAIR = STORE_COLS / 2;

	localparam logic signed [SW-1:0] HALF   = SW'(1) << (FB - 1);
	localparam logic signed [DW-1:0] MAX_V  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_V  = {1'b1, {(DW-1){1'b0}}};

	logic signed [PW-1:0] prod_s1 [STORE_COLS];
	logic                 three_d_s1;
	logic signed [SW-1:0] term    [STORE_COLS];
	logic signed [SW-1:0] part_s2 [NPAIR];
	logic signed [SW-1:0] sum_s3;
	logic signed [RW-1:0] shifted;
	logic                 fits;

	for (genvar i = 0; i < STORE_COLS; i++) begin : g_mul
		always_ff @(posedge clk) begin
			if (adv.s1) begin
				prod_s1[i] <= $signed(a_row[i]) * $signed(b_col[i]);
			end
		end

		// shear terms count twice; terms past the 2D set drop out in 2D
		if (i >= TERMS_2D) begin : g_hi
			assign term[i] = three_d_s1 ? (SW'(prod_s1[i]) <<< 1) : '0;
		end else if (i == TERMS_2D - 1) begin : g_shear2d
			assign term[i] = three_d_s1 ? SW'(prod_s1[i]) : (SW'(prod_s1[i]) <<< 1);
		end else begin : g_norm
			assign term[i] = SW'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			three_d_s1 <= three_d;
		end
	end

	for (genvar j = 0; j < NPAIR; j++) begin : g_pair
		always_ff @(posedge clk) begin
			if (adv.s2) begin
				part_s2[j] <= term[2*j] + term[2*j+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= part_s2[0] + part_s2[1] + part_s2[2] + HALF;
		end
	end

	// round half up by floor shift, then clamp to the data range
	assign shifted = sum_s3[SW-1:FB];
	assign fits    = (&shifted[RW-1:DW-1]) | ~(|shifted[RW-1:DW-1]);
	assign sat     = ~fits;

	always_comb begin
		if (fits) begin
			c = shifted[DW-1:0];
		end else if (shifted[RW-1]) begin
			c = MIN_V;
		end else begin
			c = MAX_V;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/voigt_weighted_tensor_contraction.sv
// top level: A store, three row lanes, stage control and output register
//
// Usage. The config channel writes space_dims (3 selects 3D, anything else
// 2D); it is always ready and must only be written while the block is idle.
// The item channel takes two kinds of request. A load request (func 0) writes
// one A element at row a_row, Voigt column a_voigt into the register store at
// the accepting edge and gives no result; out-of-range rows or columns are
// dropped. A column request (func 1) carries one B column and gives one result
// on the result channel: c_0..c_2 in Q format and a saturated flag. In 2D, c_2
// is zero and b_3..b_5 are ignored.
// Throughput: one request per cycle, load or column, while item.ready is high,
// set by the eighteen multipliers (three lanes of six) that work on a whole
// column at once. A column's result passes the product, pair sum and row sum
// registers, then the output register, before result.valid rises.
// A stalled receiver holds the output register; the earlier stages keep
// filling bubbles, and item.ready falls only once every stage is occupied.
// Reset clears the stage valids and sets space_dims to 2; the A store is
// undefined until loaded and must be written before it is used.
`default_nettype none

module voigt_weighted_tensor_contraction #(
	parameter int DATA_WIDTH = vwtc_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = vwtc_pkg::FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vwtc_cfg_if.sink   cfg,
	vwtc_in_if.sink    item,
	vwtc_out_if.source result
);
	import vwtc_pkg::*;

	logic [DIMS_W-1:0]                 space_dims_q;
	logic [STORE_COLS-1:0][DATA_WIDTH-1:0] a_store_q [STORE_ROWS];
	logic [STORE_COLS-1:0][DATA_WIDTH-1:0] b_vec;

	logic             accept;
	logic             load_wr;
	logic             three_d;
	vwtc_adv_t        adv;
	logic             adv_out;
	logic             v_s1, v_s2, v_s3;
	logic             three_d_s1, three_d_s2, three_d_s3;
	logic             res_v_q;

	logic signed [DATA_WIDTH-1:0] lane_c   [STORE_ROWS];
	logic                         lane_sat [STORE_ROWS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_dims_q <= DIMS_RESET;
		end else if (cfg.valid) begin
			space_dims_q <= cfg.space_dims;
		end
	end

	assign three_d = (space_dims_q == DIMS_3D);

	// each stage loads when it is empty or its contents move on
	assign adv_out    = ~res_v_q | result.ready;
	assign adv.s3     = ~v_s3 | adv_out;
	assign adv.s2     = ~v_s2 | adv.s3;
	assign adv.s1     = ~v_s1 | adv.s2;
	assign item.ready = adv.s1;

	assign accept  = item.valid & item.ready;
	assign load_wr = accept & (item.func == FUNC_LOAD);

	for (genvar r = 0; r < STORE_ROWS; r++) begin : g_row
		for (genvar k = 0; k < STORE_COLS; k++) begin : g_col
			always_ff @(posedge clk) begin
				if (load_wr && item.a_row == ROW_W'(r) && item.a_voigt == VOIGT_W'(k)) begin
					a_store_q[r][k] <= item.a_value;
				end
			end
		end
	end

	assign b_vec[0] = item.b_0;
	assign b_vec[1] = item.b_1;
	assign b_vec[2] = item.b_2;
	assign b_vec[3] = item.b_3;
	assign b_vec[4] = item.b_4;
	assign b_vec[5] = item.b_5;

	for (genvar r = 0; r < STORE_ROWS; r++) begin : g_lane
		vwtc_lane #(
			.DW (DATA_WIDTH),
			.FB (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.three_d (three_d),
			.a_row   (a_store_q[r]),
			.b_col   (b_vec),
			.c       (lane_c[r]),
			.sat     (lane_sat[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= accept & (item.func == FUNC_COLUMN);
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv.s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				res_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			three_d_s1 <= three_d;
		end
		if (adv.s2) begin
			three_d_s2 <= three_d_s1;
		end
		if (adv.s3) begin
			three_d_s3 <= three_d_s2;
		end
	end

	// merge the lanes: row 2 only counts in 3D
	always_ff @(posedge clk) begin
		if (adv_out) begin
			result.c_0       <= lane_c[0];
			result.c_1       <= lane_c[1];
			result.c_2       <= three_d_s3 ? lane_c[2] : '0;
			result.saturated <= lane_sat[0] | lane_sat[1] | (three_d_s3 & lane_sat[2]);
		end
	end

	assign result.valid = res_v_q;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the voigt weighted tensor contraction block

module testbench;
	import vwtc_pkg::*;

	localparam int DW           = DATA_WIDTH_DEF;
	localparam int FB           = FRAC_BITS_DEF;
	localparam int ACC_W        = 2 * DW + 16;
	localparam int DEPTH        = STORE_ROWS * STORE_COLS;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_STALL   = 60;

	localparam logic signed [ACC_W-1:0] SUM_MAX  = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SUM_MIN  = ~SUM_MAX;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FB - 1);
	localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] Q_ONE = DW'(1) << FB;

	// space_dims per phase: 0 and 1 also select 2D
	localparam logic [DIMS_W-1:0] PHASE_DIMS [PHASES] =
		'{DIMS_3D, 2'd0, 2'd1, DIMS_3D, DIMS_RESET, DIMS_3D, 2'd1, DIMS_3D};
	localparam int PHASE_IDLE [PHASES] = '{25, 0, 40, 15, 60, 30, 20, 0};

	typedef struct packed {
		logic [DW-1:0] c_0;
		logic [DW-1:0] c_1;
		logic [DW-1:0] c_2;
		logic          saturated;
	} column_t;

	typedef struct packed {
		logic               func;
		logic [ROW_W-1:0]   a_row;
		logic [VOIGT_W-1:0] a_voigt;
		logic [DW-1:0]      a_value;
		logic [5:0][DW-1:0] b;
		logic               known;
		column_t            known_c;
	} request_t;

	logic clk;
	logic arst_n;

	vwtc_cfg_if              cfg_bus ();
	vwtc_in_if  #(.DW(DW))   item_bus ();
	vwtc_out_if #(.DW(DW))   result_bus ();

	voigt_weighted_tensor_contraction #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.item  (item_bus),
		.result(result_bus)
	);

	// own copy of the A store and the dimension register
	logic [DW-1:0]     a_shadow [DEPTH];
	logic [DIMS_W-1:0] dims_shadow;
	column_t           columns_due [$];
	request_t          directed [$];

	int errors    = 0;
	int n_columns = 0;
	int n_loads   = 0;
	int n_dropped = 0;
	int n_clamped = 0;
	int idle_pct  = 0;
	bit quiet     = 1'b0;
	bit hold_idle = 1'b0;
	bit long_stall_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic column_t contract_column(input logic [5:0][DW-1:0] b);
		column_t res;
		logic signed [ACC_W-1:0] acc, term, ea, eb;
		logic [DW-1:0] row_out [STORE_ROWS];
		logic three_d, shear;
		int rows, terms;
		three_d = (dims_shadow == DIMS_3D);
		rows = three_d ? STORE_ROWS : 2;
		terms = three_d ? STORE_COLS : TERMS_2D;
		res = '0;
		for (int r = 0; r < STORE_ROWS; r++) begin
			row_out[r] = '0;
			if (r < rows) begin
				acc = '0;
				for (int i = 0; i < terms; i++) begin
					ea = $signed(a_shadow[r * STORE_COLS + i]);
					eb = $signed(b[i]);
					term = ea * eb;
					shear = three_d ? (i >= 3) : (i == 2);
					if (shear)
						term = term <<< 1;
					acc = acc + term;
				end
				// round half up, then clamp
				acc = (acc + HALF_LSB) >>> FB;
				if (acc > SUM_MAX) begin
					row_out[r] = Q_MAX;
					res.saturated = 1'b1;
				end else if (acc < SUM_MIN) begin
					row_out[r] = Q_MIN;
					res.saturated = 1'b1;
				end else begin
					row_out[r] = acc[DW-1:0];
				end
			end
		end
		res.c_0 = row_out[0];
		res.c_1 = row_out[1];
		res.c_2 = row_out[2];
		return res;
	endfunction

	function automatic logic is_dropped(input request_t req);
		return req.func == FUNC_LOAD &&
			(req.a_row >= STORE_ROWS || req.a_voigt >= STORE_COLS);
	endfunction

	function automatic request_t load_req(input int row, input int voigt,
			input logic [DW-1:0] value);
		request_t req;
		req = '0;
		req.func = FUNC_LOAD;
		req.a_row = ROW_W'(row);
		req.a_voigt = VOIGT_W'(voigt);
		req.a_value = value;
		req.b = {6{32'hA5A5_5A5A}};
		return req;
	endfunction

	function automatic request_t column_req(input logic [DW-1:0] b0, b1, b2, b3, b4, b5,
			input logic known, input logic [DW-1:0] c0 = '0, c1 = '0, c2 = '0,
			input logic sat = 1'b0);
		request_t req;
		req = '0;
		req.func = FUNC_COLUMN;
		req.a_value = 32'h5A5A_A5A5;
		req.b = {b5, b4, b3, b2, b1, b0};
		req.known = known;
		req.known_c = '{c_0: c0, c_1: c1, c_2: c2, saturated: sat};
		return req;
	endfunction

	function automatic logic [DW-1:0] pick_value();
		logic [DW-1:0] raw;
		raw = $urandom;
		case ($urandom_range(9))
			0, 1, 2:       return raw;
			3, 4, 5, 6, 7: return {{(DW-20){raw[19]}}, raw[19:0]};
			8:             return {{(DW-25){raw[24]}}, raw[24:0]};
			default: begin
				case ($urandom_range(5))
					0:       return Q_MAX;
					1:       return Q_MIN;
					2:       return '0;
					3:       return Q_ONE;
					4:       return -Q_ONE;
					default: return {DW{1'b1}};
				endcase
			end
		endcase
	endfunction

	function automatic request_t random_request();
		request_t req;
		int pick;
		req = '0;
		pick = $urandom_range(99);
		for (int i = 0; i < 6; i++)
			req.b[i] = pick_value();
		req.a_value = $urandom;
		if (pick < 60) begin
			req.func = FUNC_COLUMN;
			req.a_row = ROW_W'($urandom_range(3));
			req.a_voigt = VOIGT_W'($urandom_range(7));
		end else if (pick < 90) begin
			req.func = FUNC_LOAD;
			req.a_row = ROW_W'($urandom_range(STORE_ROWS - 1));
			req.a_voigt = VOIGT_W'($urandom_range(STORE_COLS - 1));
			if ($urandom_range(3) != 0)
				req.a_value = pick_value();
		end else begin
			// out-of-range load, dropped by the block
			req.func = FUNC_LOAD;
			req.a_row = ROW_W'($urandom_range(3));
			req.a_voigt = VOIGT_W'($urandom_range(7));
			if ($urandom_range(1))
				req.a_row = 2'd3;
			else
				req.a_voigt = VOIGT_W'(6 + $urandom_range(1));
		end
		return req;
	endfunction

	function automatic void check_field(input string field, input logic [DW-1:0] want, got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
		end
	endfunction

	// presents one request and returns at the edge that takes it
	task automatic offer(input request_t req);
		if (!quiet && !hold_idle && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_bus.valid   <= 1'b1;
		item_bus.func    <= req.func;
		item_bus.a_row   <= req.a_row;
		item_bus.a_voigt <= req.a_voigt;
		item_bus.a_value <= req.a_value;
		item_bus.b_0     <= req.b[0];
		item_bus.b_1     <= req.b[1];
		item_bus.b_2     <= req.b[2];
		item_bus.b_3     <= req.b[3];
		item_bus.b_4     <= req.b[4];
		item_bus.b_5     <= req.b[5];
		do @(negedge clk); while (!item_bus.ready);
		@(posedge clk);
		if (req.func == FUNC_COLUMN) begin
			columns_due.push_back(req.known ? req.known_c : contract_column(req.b));
			n_columns++;
		end else if (is_dropped(req)) begin
			n_dropped++;
		end else begin
			a_shadow[req.a_row * STORE_COLS + req.a_voigt] = req.a_value;
			n_loads++;
		end
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (columns_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [DIMS_W-1:0] dims);
		drain();
		cfg_bus.valid      <= 1'b1;
		cfg_bus.space_dims <= dims;
		do @(negedge clk); while (!cfg_bus.ready);
		@(posedge clk);
		cfg_bus.valid <= 1'b0;
		dims_shadow = dims;
	endtask

	initial begin : result_ready_drive
		int stall_left;
		stall_left = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL - 1;
				result_bus.ready <= 1'b0;
			end else if (!quiet && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				stall_left = $urandom_range(0, 4);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin : result_check
		column_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (columns_due.size() == 0) begin
				errors++;
				$display("%0t ns: result with none expected, got %h %h %h %b", $time,
					result_bus.c_0, result_bus.c_1, result_bus.c_2, result_bus.saturated);
			end else begin
				want = columns_due.pop_front();
				if (want.saturated)
					n_clamped++;
				check_field("c_0", want.c_0, result_bus.c_0);
				check_field("c_1", want.c_1, result_bus.c_1);
				check_field("c_2", want.c_2, result_bus.c_2);
				check_field("saturated", DW'(want.saturated), DW'(result_bus.saturated));
			end
		end
	end

	initial begin : stimulus
		request_t req;
		int counted;
		arst_n             = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.space_dims = DIMS_RESET;
		item_bus.valid     = 1'b0;
		item_bus.func      = FUNC_LOAD;
		item_bus.a_row     = '0;
		item_bus.a_voigt   = '0;
		item_bus.a_value   = '0;
		item_bus.b_0       = '0;
		item_bus.b_1       = '0;
		item_bus.b_2       = '0;
		item_bus.b_3       = '0;
		item_bus.b_4       = '0;
		item_bus.b_5       = '0;
		dims_shadow        = DIMS_RESET;
		foreach (a_shadow[k])
			a_shadow[k] = '0;

		// directed requests, all in 2D straight out of reset
		directed.push_back(load_req(0, 0, Q_ONE));
		directed.push_back(load_req(0, 1, Q_ONE));
		directed.push_back(load_req(0, 2, Q_ONE));
		directed.push_back(load_req(1, 0, Q_MAX));
		directed.push_back(load_req(1, 1, Q_MIN));
		directed.push_back(load_req(1, 2, '0));
		// shear weight on entry 2; b_3..b_5 must not count in 2D
		directed.push_back(column_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1'b1,
			32'h0009_0000, Q_MIN, '0, 1'b1));
		directed.push_back(column_req('0, '0, '0, Q_MAX, Q_MAX, Q_MAX, 1'b1,
			'0, '0, '0, 1'b0));
		directed.push_back(column_req(Q_MAX, '0, '0, '0, '0, '0, 1'b1,
			Q_MAX, Q_MAX, '0, 1'b1));
		directed.push_back(column_req('0, Q_MIN, '0, '0, '0, '0, 1'b1,
			Q_MIN, Q_MAX, '0, 1'b1));
		directed.push_back(column_req('0, '0, 32'h4000_0000, '0, '0, '0, 1'b1,
			Q_MAX, '0, '0, 1'b1));
		directed.push_back(column_req(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
		// half an lsb either side of zero
		directed.push_back(load_req(0, 0, 32'h0000_8000));
		directed.push_back(column_req(32'h1, '0, '0, '0, '0, '0, 1'b0));
		directed.push_back(column_req({DW{1'b1}}, '0, '0, '0, '0, '0, 1'b0));
		// dropped loads, then entries outside the 2D window
		directed.push_back(load_req(3, 0, 32'hDEAD_BEEF));
		directed.push_back(load_req(1, 6, 32'hDEAD_BEEF));
		directed.push_back(load_req(0, 7, 32'hDEAD_BEEF));
		directed.push_back(load_req(2, 3, Q_MIN));
		directed.push_back(load_req(0, 4, Q_MAX));
		directed.push_back(column_req(32'h0001_8000, 32'hFFFE_8000, 32'h0000_4000,
			Q_MIN, Q_MAX, 32'h1, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k])
			offer(directed[k]);

		for (int p = 0; p < PHASES; p++) begin
			write_dims(PHASE_DIMS[p]);
			idle_pct = PHASE_IDLE[p];
			quiet = (p == PHASES - 1);
			// fill the whole store before any 3D column reads it
			if (p == 0) begin
				for (int e = 0; e < DEPTH; e++)
					offer(load_req(e / STORE_COLS, e % STORE_COLS, pick_value()));
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if (p == 2 && counted == 20) begin
					long_stall_req = 1'b1;
					hold_idle = 1'b1;
				end
				if (p == 2 && counted == 70)
					hold_idle = 1'b0;
				if (p == 4 && counted == 50)
					drain();
				req = random_request();
				offer(req);
				if (!is_dropped(req))
					counted++;
			end
		end
		drain();

		$display("covered %0d columns, %0d loads and %0d dropped loads over %0d dims settings",
			n_columns, n_loads, n_dropped, PHASES + 1);
		$display("%0d columns expected a clamped entry; %0d mismatches", n_clamped, errors);
		if (errors == 0 && columns_due.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
